// ===== sv/utf8_transliterating_slug_filter_unit_assert.svh =====
// Assertion macros shared by the slug filter RTL.
`ifndef UTF8_TRANSLITERATING_SLUG_FILTER_UNIT_ASSERT_SVH
`define UTF8_TRANSLITERATING_SLUG_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every rising clock edge.
`define UTSF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slug filter assertion failed");
// Next-cycle implication checked at every rising clock edge.
`define UTSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slug filter assertion failed");
`else
`define UTSF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define UTSF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/utsf_pkg.sv =====
// Types, character codes and the transliteration function of the slug filter.
package utsf_pkg;

   localparam int unsigned CP_W      = 21;
   localparam int unsigned CHAR_W    = 7;
   localparam int unsigned GROUP_MAX = 4;
   localparam int unsigned USER_END  = 0;
   localparam int unsigned USER_EMPTY = 1;

   localparam logic [7:0] CAP_RESET = 8'd32;

   localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CH_UNDER = 7'h5F;
   localparam logic [CHAR_W-1:0] CH_0     = 7'h30;
   localparam logic [CHAR_W-1:0] CH_9     = 7'h39;
   localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;
   localparam logic [CHAR_W-1:0] CH_UZ    = 7'h5A;
   localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;
   localparam logic [CHAR_W-1:0] CH_LZ    = 7'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFS = 7'd32;

   // One transliterated piece: zero to three characters.
   typedef struct packed {
      logic [1:0]        len;
      logic [CHAR_W-1:0] c0;
      logic [CHAR_W-1:0] c1;
      logic [CHAR_W-1:0] c2;
   } piece_type;

   function automatic piece_type mk(logic [1:0] len, logic [7:0] a, logic [7:0] b,
                                    logic [7:0] c);
      piece_type p;
      p.len = len;
      p.c0  = a[CHAR_W-1:0];
      p.c1  = b[CHAR_W-1:0];
      p.c2  = c[CHAR_W-1:0];
      return p;
   endfunction

   // Cyrillic letter table, indexed by offset from the first letter.
   function automatic piece_type cyr_piece(logic [4:0] idx);
      piece_type p;
      unique case (idx)
         5'd0:  p = mk(2'd1, "a", 8'h0, 8'h0);
         5'd1:  p = mk(2'd1, "b", 8'h0, 8'h0);
         5'd2:  p = mk(2'd1, "v", 8'h0, 8'h0);
         5'd3:  p = mk(2'd1, "g", 8'h0, 8'h0);
         5'd4:  p = mk(2'd1, "d", 8'h0, 8'h0);
         5'd5:  p = mk(2'd1, "e", 8'h0, 8'h0);
         5'd6:  p = mk(2'd2, "z", "h", 8'h0);
         5'd7:  p = mk(2'd1, "z", 8'h0, 8'h0);
         5'd8:  p = mk(2'd1, "i", 8'h0, 8'h0);
         5'd9:  p = mk(2'd1, "j", 8'h0, 8'h0);
         5'd10: p = mk(2'd1, "k", 8'h0, 8'h0);
         5'd11: p = mk(2'd1, "l", 8'h0, 8'h0);
         5'd12: p = mk(2'd1, "m", 8'h0, 8'h0);
         5'd13: p = mk(2'd1, "n", 8'h0, 8'h0);
         5'd14: p = mk(2'd1, "o", 8'h0, 8'h0);
         5'd15: p = mk(2'd1, "p", 8'h0, 8'h0);
         5'd16: p = mk(2'd1, "r", 8'h0, 8'h0);
         5'd17: p = mk(2'd1, "s", 8'h0, 8'h0);
         5'd18: p = mk(2'd1, "t", 8'h0, 8'h0);
         5'd19: p = mk(2'd1, "u", 8'h0, 8'h0);
         5'd20: p = mk(2'd1, "f", 8'h0, 8'h0);
         5'd21: p = mk(2'd1, "h", 8'h0, 8'h0);
         5'd22: p = mk(2'd1, "c", 8'h0, 8'h0);
         5'd23: p = mk(2'd2, "c", "h", 8'h0);
         5'd24: p = mk(2'd2, "s", "h", 8'h0);
         5'd25: p = mk(2'd3, "s", "c", "h");
         5'd26: p = mk(2'd0, 8'h0, 8'h0, 8'h0);
         5'd27: p = mk(2'd1, "y", 8'h0, 8'h0);
         5'd28: p = mk(2'd0, 8'h0, 8'h0, 8'h0);
         5'd29: p = mk(2'd1, "e", 8'h0, 8'h0);
         5'd30: p = mk(2'd2, "y", "u", 8'h0);
         default: p = mk(2'd2, "y", "a", 8'h0);
      endcase
      return p;
   endfunction

   // Latin letters with diacritics that map to one plain letter.
   function automatic piece_type dia_piece(logic [9:0] code);
      piece_type p;
      unique case (code)
         10'h0E4, 10'h0C4, 10'h0E0, 10'h0E2, 10'h0E3, 10'h105, 10'h0E5, 10'h0E6,
         10'h103: p = mk(2'd1, "a", 8'h0, 8'h0);
         10'h0F6, 10'h0D6, 10'h0F4, 10'h0F5, 10'h0F3, 10'h0F8,
         10'h151: p = mk(2'd1, "o", 8'h0, 8'h0);
         10'h0FC, 10'h0DC, 10'h0F9, 10'h0FB, 10'h16F,
         10'h171: p = mk(2'd1, "u", 8'h0, 8'h0);
         10'h0DF, 10'h15B, 10'h161, 10'h219,
         10'h15F: p = mk(2'd1, "s", 8'h0, 8'h0);
         10'h0E7, 10'h107, 10'h10D: p = mk(2'd1, "c", 8'h0, 8'h0);
         10'h0E8, 10'h0E9, 10'h0EA, 10'h0EB, 10'h119,
         10'h11B: p = mk(2'd1, "e", 8'h0, 8'h0);
         10'h0EE, 10'h0EF, 10'h131: p = mk(2'd1, "i", 8'h0, 8'h0);
         10'h0F1, 10'h144, 10'h148: p = mk(2'd1, "n", 8'h0, 8'h0);
         10'h142: p = mk(2'd1, "l", 8'h0, 8'h0);
         10'h17A, 10'h17C, 10'h17E: p = mk(2'd1, "z", 8'h0, 8'h0);
         10'h10F: p = mk(2'd1, "d", 8'h0, 8'h0);
         10'h159: p = mk(2'd1, "r", 8'h0, 8'h0);
         10'h165, 10'h21B: p = mk(2'd1, "t", 8'h0, 8'h0);
         10'h11F: p = mk(2'd1, "g", 8'h0, 8'h0);
         default: p = mk(2'd0, 8'h0, 8'h0, 8'h0);
      endcase
      return p;
   endfunction

   // Transliterate one code point to a lower-case ASCII piece.
   function automatic piece_type translit(logic [CP_W-1:0] cp);
      piece_type p;
      logic      ascii;
      logic      low11;
      logic [6:0] c;
      ascii = (cp[CP_W-1:7] == '0);
      low11 = (cp[CP_W-1:11] == '0);
      c     = cp[6:0];
      p     = mk(2'd0, 8'h0, 8'h0, 8'h0);
      priority if (ascii && c >= CH_UA && c <= CH_UZ) begin
         p.len = 2'd1;
         p.c0  = c + CASE_OFS;
      end else if (ascii && ((c >= CH_LA && c <= CH_LZ) || (c >= CH_0 && c <= CH_9) ||
                             c == CH_UNDER || c == CH_DASH)) begin
         p.len = 2'd1;
         p.c0  = c;
      end else if (ascii && c == CH_SPACE) begin
         p.len = 2'd1;
         p.c0  = CH_DASH;
      end else if (low11 && cp[10:0] >= 11'h410 && cp[10:0] <= 11'h44F) begin
         p = cyr_piece({~cp[4], cp[3:0]});
      end else if (low11 && (cp[10:0] == 11'h456 || cp[10:0] == 11'h406)) begin
         p = mk(2'd1, "i", 8'h0, 8'h0);
      end else if (low11 && (cp[10:0] == 11'h457 || cp[10:0] == 11'h407)) begin
         p = mk(2'd2, "y", "i", 8'h0);
      end else if (low11 && (cp[10:0] == 11'h454 || cp[10:0] == 11'h404)) begin
         p = mk(2'd2, "y", "e", 8'h0);
      end else if (low11 && (cp[10:0] == 11'h491 || cp[10:0] == 11'h490)) begin
         p = mk(2'd1, "g", 8'h0, 8'h0);
      end else if (low11 && (cp[10:0] == 11'h451 || cp[10:0] == 11'h401)) begin
         p = mk(2'd2, "y", "o", 8'h0);
      end else if (cp[CP_W-1:10] == '0) begin
         p = dia_piece(cp[9:0]);
      end else begin
         p = mk(2'd0, 8'h0, 8'h0, 8'h0);
      end
      return p;
   endfunction

endpackage

// ===== sv/utf8_transliterating_slug_filter_unit.sv =====
// Top level of the UTF-8 to ASCII slug filter.

// The block takes one UTF-8 byte per word and produces the lower-case ASCII
// slug of a zero-terminated name, one character per result word. A byte is
// taken in every cycle while each byte yields at most one character and the
// result side is ready; a byte that yields more (a held dash plus up to three
// letters) fills the output group register, which hands out one word per
// cycle while rsp_tready is high. Bytes that yield nothing still pass at one
// per cycle while a group drains. The zero byte ends the name with a single
// end word whose tuser flags mark the end and whether the name came out empty.
`include "utf8_transliterating_slug_filter_unit_assert.svh"

module utf8_transliterating_slug_filter_unit (
   input  logic       clock,
   input  logic       reset,
   // Configuration: name_capacity.
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   // Input words; tdata: in_byte[7:0].
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   // Result words; tdata: out_char[6:0], zero[7].
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   // tuser: end_of_name[0], name_empty[1].
   output logic [1:0] rsp_tuser,
   // tlast: last_of_run.
   output logic       rsp_tlast
);

   localparam int unsigned CW = utsf_pkg::CHAR_W;
   localparam int unsigned GM = utsf_pkg::GROUP_MAX;

   logic [7:0]                 cap_ff;
   logic                       in_valid_ff;
   logic [7:0]                 in_byte_ff;
   logic [utsf_pkg::CP_W-1:0]  part_ff, part_in;
   logic [1:0]                 need_ff, need_in;
   logic [7:0]                 raw_ff, raw_in;
   logic                       any_ff, any_in;
   logic                       dash_ff, dash_in;
   logic [CW-1:0]              grp_char_ff [GM];
   logic [CW-1:0]              grp_char_in [GM];
   logic [2:0]                 grp_left_ff;
   logic                       grp_end_ff, grp_end_in;
   logic                       grp_empty_ff, grp_empty_in;

   logic [utsf_pkg::CP_W-1:0]  cp;
   logic                       cp_ready;
   utsf_pkg::piece_type        piece;
   logic [9:0]                 len_sum;
   logic                       keep;
   logic                       dash_piece;
   logic [2:0]                 n_out;
   logic                       grp_free;
   logic                       advance;
   logic                       rsp_fire;

   // Assemble code points from the registered byte.
   always_comb begin
      part_in  = part_ff;
      need_in  = need_ff;
      cp       = '0;
      cp_ready = 1'b0;
      priority if (in_byte_ff == 8'd0) begin
         // The zero byte drops any unfinished sequence.
         part_in = '0;
         need_in = 2'd0;
      end else if (need_ff != 2'd0) begin
         part_in  = {part_ff[utsf_pkg::CP_W-7:0], in_byte_ff[5:0]};
         need_in  = need_ff - 2'd1;
         cp       = part_in;
         cp_ready = (need_ff == 2'd1);
      end else if (!in_byte_ff[7]) begin
         cp       = {13'd0, in_byte_ff};
         cp_ready = 1'b1;
      end else if (in_byte_ff[7:5] == 3'b110) begin
         part_in = {16'd0, in_byte_ff[4:0]};
         need_in = 2'd1;
      end else if (in_byte_ff[7:4] == 4'b1110) begin
         part_in = {17'd0, in_byte_ff[3:0]};
         need_in = 2'd2;
      end else if (in_byte_ff[7:3] == 5'b11110) begin
         part_in = {18'd0, in_byte_ff[2:0]};
         need_in = 2'd3;
      end else begin
         part_in = part_ff;
      end
   end

   // Transliterate, apply the length limit and build the result group.
   always_comb begin
      piece      = utsf_pkg::translit(cp);
      len_sum    = {2'd0, raw_ff} + {8'd0, piece.len} + 10'd1;
      keep       = cp_ready && (piece.len != 2'd0) && (len_sum < {2'd0, cap_ff});
      dash_piece = (piece.len == 2'd1) && (piece.c0 == utsf_pkg::CH_DASH);
      raw_in     = raw_ff;
      any_in     = any_ff;
      dash_in    = dash_ff;
      n_out      = 3'd0;
      grp_end_in   = 1'b0;
      grp_empty_in = 1'b0;
      for (int i = 0; i < GM; i++) begin
         grp_char_in[i] = '0;
      end
      if (in_byte_ff == 8'd0) begin
         // End of name: one end word, then clear the name state.
         n_out        = 3'd1;
         grp_end_in   = 1'b1;
         grp_empty_in = !any_ff;
         raw_in       = 8'd0;
         any_in       = 1'b0;
         dash_in      = 1'b0;
      end else if (keep) begin
         raw_in = raw_ff + {6'd0, piece.len};
         if (dash_piece) begin
            dash_in = dash_ff | any_ff;
         end else begin
            n_out   = {1'b0, piece.len} + {2'd0, dash_ff};
            any_in  = 1'b1;
            dash_in = 1'b0;
            if (dash_ff) begin
               grp_char_in[0] = utsf_pkg::CH_DASH;
               grp_char_in[1] = piece.c0;
               grp_char_in[2] = piece.c1;
               grp_char_in[3] = piece.c2;
            end else begin
               grp_char_in[0] = piece.c0;
               grp_char_in[1] = piece.c1;
               grp_char_in[2] = piece.c2;
            end
         end
      end
   end

   // Handshake: a byte moves on when it yields nothing or the group frees up.
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign grp_free   = (grp_left_ff == 3'd0) || (grp_left_ff == 3'd1 && rsp_tready);
   assign advance    = in_valid_ff && ((n_out == 3'd0) || grp_free);
   assign req_tready = !in_valid_ff || advance;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= utsf_pkg::CAP_RESET;
         in_valid_ff  <= 1'b0;
         part_ff      <= '0;
         need_ff      <= 2'd0;
         raw_ff       <= 8'd0;
         any_ff       <= 1'b0;
         dash_ff      <= 1'b0;
         grp_left_ff  <= 3'd0;
         grp_end_ff   <= 1'b0;
         grp_empty_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            part_ff <= part_in;
            need_ff <= need_in;
            raw_ff  <= raw_in;
            any_ff  <= any_in;
            dash_ff <= dash_in;
         end
         if (advance && n_out != 3'd0) begin
            grp_left_ff  <= n_out;
            grp_end_ff   <= grp_end_in;
            grp_empty_ff <= grp_empty_in;
         end else if (rsp_fire) begin
            grp_left_ff <= grp_left_ff - 3'd1;
         end
      end
   end

   // Payload registers: input byte and the group characters.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && n_out != 3'd0) begin
         for (int i = 0; i < GM; i++) begin
            grp_char_ff[i] <= grp_char_in[i];
         end
      end else if (rsp_fire) begin
         for (int i = 0; i < GM - 1; i++) begin
            grp_char_ff[i] <= grp_char_ff[i+1];
         end
      end
   end

   // Result word from the head of the group.
   assign rsp_tvalid = (grp_left_ff != 3'd0);
   assign rsp_tdata  = {1'b0, grp_char_ff[0]};
   assign rsp_tuser  = {grp_empty_ff, grp_end_ff};
   assign rsp_tlast  = (grp_left_ff == 3'd1);

   // An end word is always the last word of its byte.
   `UTSF_ASSERT_IMPL(a_end_is_last, clock, reset,
                     rsp_tvalid && rsp_tuser[utsf_pkg::USER_END], rsp_tlast)
   // A dash is only ever sent in front of another character.
   `UTSF_ASSERT_IMPL(a_dash_not_last, clock, reset,
                     rsp_tvalid && !rsp_tuser[utsf_pkg::USER_END] &&
                     rsp_tdata[CW-1:0] == utsf_pkg::CH_DASH, !rsp_tlast)
   // A held byte stays put until it advances.
   `UTSF_ASSERT_NEXT(a_hold_byte, clock, reset,
                     in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))

endmodule

// ===== dv/tb_utf8_transliterating_slug_filter_unit.sv =====
// Self-checking testbench of the UTF-8 to ASCII slug filter: stimulus, predictor and scoreboard.
`timescale 1ns / 1ps

module tb_utf8_transliterating_slug_filter_unit;

   localparam int unsigned CP_W   = utsf_pkg::CP_W;
   localparam int unsigned CHAR_W = utsf_pkg::CHAR_W;

   // A run is at most about 2000 bytes, on average no more than two words per byte, each word
   // possibly waiting out stalls on the result side.
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned REPORT_MAX    = 10;
   localparam int unsigned GAP_PERCENT   = 36;
   localparam int unsigned PHASE_BYTES   = 55;
   localparam int unsigned PHASE_COUNT   = 8;
   localparam int unsigned NO_GAP_PHASE  = 5;

   // One result word as it is compared.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              eon;
      logic              empty;
      logic              last;
   } slug_word_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       csr_we     = 1'b0;
   logic [7:0] csr_wdata  = 8'd0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   logic [7:0]    pending_bytes [$];
   slug_word_type slug_due [$];
   logic          req_fire = 1'b0;
   logic          no_gaps  = 1'b0;
   int            bad_words = 0;
   int            cycle_count;
   slug_word_type seen;
   slug_word_type want;

   // Predictor state: the capacity register and the per-name decoder state.
   logic [7:0]      cap_model = utsf_pkg::CAP_RESET;
   logic [CP_W-1:0] cp_acc    = '0;
   logic [1:0]      cont_left = 2'd0;
   logic [7:0]      raw_len   = 8'd0;
   logic            any_out   = 1'b0;
   logic            dash_held = 1'b0;

   // Opening name: leading space, overlong 'A', dash and space run, Zhe with a bad
   // continuation byte, stray bytes, Shcha, dropped 3- and 4-byte forms, a-umlaut, DEL,
   // a trailing dash; then an empty name and one cut short by its terminator.
   logic [7:0] opening [28] = '{
      8'h20, 8'hC1, 8'h81, 8'h2D, 8'h20, 8'hD0, 8'h16, 8'hFF, 8'h80, 8'hD1,
      8'h89, 8'h20, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC3,
      8'hA4, 8'h7F, 8'h20, 8'h00, 8'h00, 8'hE2, 8'h82, 8'h00
   };

   utf8_transliterating_slug_filter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // in_byte[7:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // out_char[6:0], zero[7]
      .rsp_tuser  (rsp_tuser),   // end_of_name[0], name_empty[1]
      .rsp_tlast  (rsp_tlast)
   );

   // 50 MHz clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Cyrillic letters, by offset from the first letter of either case.
   function automatic string cyrillic_latin(int idx);
      string s;
      case (idx)
         0: s = "a";    1: s = "b";    2: s = "v";    3: s = "g";
         4: s = "d";    5: s = "e";    6: s = "zh";   7: s = "z";
         8: s = "i";    9: s = "j";    10: s = "k";   11: s = "l";
         12: s = "m";   13: s = "n";   14: s = "o";   15: s = "p";
         16: s = "r";   17: s = "s";   18: s = "t";   19: s = "u";
         20: s = "f";   21: s = "h";   22: s = "c";   23: s = "ch";
         24: s = "sh";  25: s = "sch"; 27: s = "y";   29: s = "e";
         30: s = "yu";  31: s = "ya";
         default: s = "";
      endcase
      return s;
   endfunction

   // Latin letters with diacritics that fold to one plain letter.
   function automatic string plain_letter(logic [CP_W-1:0] cp);
      string s;
      case (cp)
         21'h0E4, 21'h0C4, 21'h0E0, 21'h0E2, 21'h0E3, 21'h105, 21'h0E5, 21'h0E6,
         21'h103: s = "a";
         21'h0F6, 21'h0D6, 21'h0F4, 21'h0F5, 21'h0F3, 21'h0F8, 21'h151: s = "o";
         21'h0FC, 21'h0DC, 21'h0F9, 21'h0FB, 21'h16F, 21'h171: s = "u";
         21'h0DF, 21'h15B, 21'h161, 21'h219, 21'h15F: s = "s";
         21'h0E7, 21'h107, 21'h10D: s = "c";
         21'h0E8, 21'h0E9, 21'h0EA, 21'h0EB, 21'h119, 21'h11B: s = "e";
         21'h0EE, 21'h0EF, 21'h131: s = "i";
         21'h0F1, 21'h144, 21'h148: s = "n";
         21'h142: s = "l";
         21'h17A, 21'h17C, 21'h17E: s = "z";
         21'h10F: s = "d";
         21'h159: s = "r";
         21'h165, 21'h21B: s = "t";
         21'h11F: s = "g";
         default: s = "";
      endcase
      return s;
   endfunction

   // Lower-case ASCII text for one code point; empty when the code point is dropped.
   function automatic string latin_for(logic [CP_W-1:0] cp);
      logic       ascii;
      logic [6:0] c;
      string      s;
      ascii = (cp[CP_W-1:7] == '0);
      c     = cp[6:0];
      s     = "";
      if (ascii && c >= utsf_pkg::CH_UA && c <= utsf_pkg::CH_UZ) begin
         s = $sformatf("%c", c + utsf_pkg::CASE_OFS);
      end else if (ascii && ((c >= utsf_pkg::CH_LA && c <= utsf_pkg::CH_LZ) ||
                             (c >= utsf_pkg::CH_0 && c <= utsf_pkg::CH_9) ||
                             c == utsf_pkg::CH_UNDER || c == utsf_pkg::CH_DASH)) begin
         s = $sformatf("%c", c);
      end else if (ascii && c == utsf_pkg::CH_SPACE) begin
         s = "-";
      end else if (cp >= 21'h430 && cp <= 21'h44F) begin
         s = cyrillic_latin(int'(cp) - 'h430);
      end else if (cp >= 21'h410 && cp <= 21'h42F) begin
         s = cyrillic_latin(int'(cp) - 'h410);
      end else if (cp == 21'h456 || cp == 21'h406) begin
         s = "i";
      end else if (cp == 21'h457 || cp == 21'h407) begin
         s = "yi";
      end else if (cp == 21'h454 || cp == 21'h404) begin
         s = "ye";
      end else if (cp == 21'h491 || cp == 21'h490) begin
         s = "g";
      end else if (cp == 21'h451 || cp == 21'h401) begin
         s = "yo";
      end else begin
         s = plain_letter(cp);
      end
      return s;
   endfunction

   // Advance the predictor by one accepted byte and queue the words it should cause.
   task automatic slug_predict(input logic [7:0] b);
      logic [CP_W-1:0] cp;
      logic            have_cp;
      string           piece;
      logic [7:0]      c;
      slug_word_type   burst [4];
      slug_word_type   w;
      int              n;
      cp      = '0;
      have_cp = 1'b0;
      piece   = "";
      n       = 0;
      if (b == 8'h00) begin
         // The terminator drops any unfinished sequence and any held dash.
         w = {7'd0, 1'b1, !any_out, 1'b1};
         slug_due.push_back(w);
         cp_acc    = '0;
         cont_left = 2'd0;
         raw_len   = 8'd0;
         any_out   = 1'b0;
         dash_held = 1'b0;
      end else begin
         // Sequence assembly; continuation bytes are not checked.
         if (cont_left != 2'd0) begin
            cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
               cp      = cp_acc;
               have_cp = 1'b1;
            end
         end else if (b[7] == 1'b0) begin
            cp      = CP_W'(b);
            have_cp = 1'b1;
         end else if (b[7:5] == 3'b110) begin
            cp_acc    = CP_W'(b[4:0]);
            cont_left = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            cp_acc    = CP_W'(b[3:0]);
            cont_left = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            cp_acc    = CP_W'(b[2:0]);
            cont_left = 2'd3;
         end

         if (have_cp) begin
            piece = latin_for(cp);
            // Keep the piece only if it still fits below capacity minus one.
            if (piece.len() != 0 && int'(raw_len) + piece.len() + 1 < int'(cap_model)) begin
               raw_len = raw_len + 8'(piece.len());
               for (int i = 0; i < piece.len(); i++) begin
                  c = piece[i];
                  if (c[6:0] == utsf_pkg::CH_DASH) begin
                     if (any_out) begin
                        dash_held = 1'b1;
                     end
                  end else begin
                     if (dash_held) begin
                        burst[n]  = {utsf_pkg::CH_DASH, 3'b000};
                        n++;
                        dash_held = 1'b0;
                     end
                     burst[n] = {c[6:0], 3'b000};
                     n++;
                     any_out = 1'b1;
                  end
               end
               for (int i = 0; i < n; i++) begin
                  w      = burst[i];
                  w.last = (i == n - 1);
                  slug_due.push_back(w);
               end
            end
         end
      end
   endtask

   // Scoreboard: compare each result word first, then predict from the accepted byte.
   always @(posedge clock) begin
      if (reset) begin
         req_fire  = 1'b0;
         cap_model = utsf_pkg::CAP_RESET;
         cp_acc    = '0;
         cont_left = 2'd0;
         raw_len   = 8'd0;
         any_out   = 1'b0;
         dash_held = 1'b0;
      end else begin
         req_fire = req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tdata[CHAR_W-1:0], rsp_tuser[utsf_pkg::USER_END],
                    rsp_tuser[utsf_pkg::USER_EMPTY], rsp_tlast};
            if (slug_due.size() == 0) begin
               bad_words++;
               if (bad_words <= REPORT_MAX) begin
                  $display("%0t: word with nothing expected: char %h end %b empty %b last %b",
                           $time, seen.ch, seen.eon, seen.empty, seen.last);
               end
            end else begin
               want = slug_due.pop_front();
               if (seen !== want || rsp_tdata[7] !== 1'b0) begin
                  bad_words++;
                  if (bad_words <= REPORT_MAX) begin
                     $display("%0t: word mismatch: expected char %h end %b empty %b last %b",
                              $time, want.ch, want.eon, want.empty, want.last);
                     $display("%0t:   actual char %h end %b empty %b last %b pad %b",
                              $time, seen.ch, seen.eon, seen.empty, seen.last, rsp_tdata[7]);
                  end
               end
            end
         end
         if (req_fire) begin
            slug_predict(req_tdata);
         end
      end
   end

   // Byte driver and result-side stalls, both changing on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (pending_bytes.size() != 0 &&
                (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
      end
   end

   // UTF-8 encoding of one code point into the byte queue.
   task automatic queue_code_point(input logic [CP_W-1:0] cp);
      if (cp < 21'h80) begin
         pending_bytes.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
         pending_bytes.push_back({3'b110, cp[10:6]});
         pending_bytes.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         pending_bytes.push_back({4'b1110, cp[15:12]});
         pending_bytes.push_back({2'b10, cp[11:6]});
         pending_bytes.push_back({2'b10, cp[5:0]});
      end else begin
         pending_bytes.push_back({5'b11110, cp[20:18]});
         pending_bytes.push_back({2'b10, cp[17:12]});
         pending_bytes.push_back({2'b10, cp[11:6]});
         pending_bytes.push_back({2'b10, cp[5:0]});
      end
   endtask

   // One random name: mostly well-formed text of mixed scripts, some noise, then zero.
   task automatic queue_random_name();
      int              count;
      int              pick;
      logic [CP_W-1:0] cp;
      count = ($urandom_range(9) == 0) ? int'($urandom_range(40)) : int'($urandom_range(12));
      for (int k = 0; k < count; k++) begin
         pick = int'($urandom_range(99));
         if (pick < 30) begin
            queue_code_point(CP_W'($urandom_range(32, 126)));
         end else if (pick < 38) begin
            queue_code_point($urandom_range(1) ? CP_W'(utsf_pkg::CH_SPACE) :
                                                 CP_W'(utsf_pkg::CH_DASH));
         end else if (pick < 48) begin
            queue_code_point(CP_W'($urandom_range(utsf_pkg::CH_UA, utsf_pkg::CH_UZ)));
         end else if (pick < 63) begin
            queue_code_point(CP_W'($urandom_range('h400, 'h45F)));
         end else if (pick < 66) begin
            queue_code_point(CP_W'($urandom_range('h490, 'h491)));
         end else if (pick < 81) begin
            if ($urandom_range(3) == 0) begin
               queue_code_point(CP_W'($urandom_range('h218, 'h21B)));
            end else begin
               queue_code_point(CP_W'($urandom_range('hC0, 'h17F)));
            end
         end else if (pick < 86) begin
            queue_code_point(CP_W'($urandom_range('h800, 'hFFFF)));
         end else if (pick < 89) begin
            queue_code_point(CP_W'($urandom_range('h10000, 'h10FFFF)));
         end else if (pick < 92) begin
            // Overlong two-byte form of an ASCII character.
            cp = CP_W'($urandom_range(1, 127));
            pending_bytes.push_back({6'b110000, cp[7:6]});
            pending_bytes.push_back({2'b10, cp[5:0]});
         end else if (pick < 96) begin
            queue_code_point(CP_W'($urandom_range(1, 127)));
         end else begin
            pending_bytes.push_back(8'($urandom_range(1, 255)));
         end
      end
      // Now and then a sequence is cut short by the terminator.
      if ($urandom_range(19) == 0) begin
         pending_bytes.push_back(8'($urandom_range('hC0, 'hF7)));
      end
      pending_bytes.push_back(8'h00);
   endtask

   // Wait until every byte is taken and every word has come, then let the block drain.
   task automatic settle();
      while (pending_bytes.size() != 0 || req_tvalid || slug_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Capacity register write, done only while the block is idle.
   task automatic write_capacity(input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      cap_model = value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Run sequence: reset, the opening names at the reset capacity, then random phases.
   initial begin
      logic [7:0] cap;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening[i]) begin
         pending_bytes.push_back(opening[i]);
      end
      settle();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: cap = 8'd0;
            1: cap = 8'd1;
            2: cap = 8'd2;
            3: cap = 8'd255;
            4: cap = 8'd6;
            6: cap = 8'd32;
            default: cap = 8'($urandom_range(3, 64));
         endcase
         write_capacity(cap);
         no_gaps = (p == NO_GAP_PHASE);
         while (pending_bytes.size() < PHASE_BYTES) begin
            queue_random_name();
         end
         settle();
      end

      if (bad_words == 0 && slug_due.size() == 0) begin
         $display("utf8_transliterating_slug_filter_unit regression: pass");
      end else begin
         $display("utf8_transliterating_slug_filter_unit regression: fail");
      end
      $finish;
   end

   // Watchdog on the whole run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("utf8_transliterating_slug_filter_unit regression: fail");
      $finish;
   end

endmodule
